FILE: rtl/complex_pair_set_table_core_defines.svh
// Assertion macros shared by the set table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef COMPLEX_PAIR_SET_TABLE_CORE_DEFINES_SVH
`define COMPLEX_PAIR_SET_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CPST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CPST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cpst_pkg.sv
// Package for the complex pair set table: field types, command and status codes,
// and the control group handed to every table cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpst_pkg;

	localparam int CMD_W    = 2;
	localparam int PART_W   = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 5;

	typedef logic [CMD_W-1:0]           cmd_t;
	typedef logic signed [PART_W-1:0]   part_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic [ENTRY_W-1:0]         entry_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;
	localparam cmd_t CMD_LOOKUP = 2'd2;

	localparam status_t STS_OK   = 2'd0;
	localparam status_t STS_MISS = 2'd1;
	localparam status_t STS_FULL = 2'd2;

	// Control shared by all cells for one request.
	typedef struct packed {
		logic cmp;   // register the match of the request pair
		logic ins;   // append the request pair at the tail cell
		logic del;   // close the gap left by the matching cell
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/cpst_if.sv
// Request and result channel interfaces of the complex pair set table.
// Depends on cpst_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface cpst_req_if;
	import cpst_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  command;
	part_t real_part;
	part_t imag_part;

	modport source (output valid, output command, output real_part, output imag_part,
		input ready);
	modport sink (input valid, input command, input real_part, input imag_part,
		output ready);
endinterface

interface cpst_rsp_if;
	import cpst_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	entry_t  entry_count;

	modport source (output valid, output status, output entry_count, input ready);
	modport sink (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/cpst_cell.sv
// One entry of the set table: a stored pair, its match flag and the shift link
// to its neighbour. Depends on cpst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpst_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cpst_pkg::cell_ctl_t  ctl,
	input  wire                  occupied,
	input  wire                  is_tail,
	input  cpst_pkg::part_t      op_re,
	input  cpst_pkg::part_t      op_im,
	input  cpst_pkg::part_t      nxt_re,
	input  cpst_pkg::part_t      nxt_im,
	input  wire                  shift_in,
	output cpst_pkg::part_t      cur_re,
	output cpst_pkg::part_t      cur_im,
	output logic                 hit_q,
	output logic                 shift_out
);
	import cpst_pkg::*;

	part_t re_q;
	part_t im_q;

	// A cell at or beyond the deleted entry takes its neighbour's pair.
	assign shift_out = shift_in | hit_q;
	assign cur_re    = re_q;
	assign cur_im    = im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp) begin
			hit_q <= occupied && (re_q == op_re) && (im_q == op_im);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && is_tail) begin
			re_q <= op_re;
			im_q <= op_im;
		end else if (ctl.del && shift_out) begin
			re_q <= nxt_re;
			im_q <= nxt_im;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/complex_pair_set_table_core.sv
// Complex pair set table: insert, delete and lookup of integer complex pairs
// kept in insertion order in a row of cells. Depends on cpst_pkg, cpst_if,
// cpst_cell and the assertion macro header.
//
// Usage:
//   req carries one request: a command (insert, delete, lookup) and a pair.
//   rsp returns exactly one result per request: a status and the entry count
//   after the request has taken effect.
//   A request accepted into the input registers is compared against every cell
//   in the compare state, its match registered, and applied in the apply state,
//   when the result is loaded into the output register. A new request can be
//   accepted in the apply cycle, while the previous one is applied, but not
//   while it is compared; the request rate is set by the registered compare of
//   all cells followed by the apply step that shifts the row.
//   Reset empties the table; stored pairs are not cleared, only the count.
//   When the receiver stalls, the result holds in the output register; one
//   further request may be accepted and compared, and it then waits in the
//   apply step with req.ready low until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_pair_set_table_core_defines.svh"

module complex_pair_set_table_core #(
	parameter int unsigned CAPACITY = 16
) (
	input wire         clk,
	input wire         arst_n,
	cpst_req_if.sink   req,
	cpst_rsp_if.source rsp
);
	import cpst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	status_t             status_q;
	entry_t              entry_q;

	cmd_t                cmd_s1;
	part_t               re_s1;
	part_t               im_s1;

	cell_ctl_t           ctl;
	logic [CAPACITY-1:0] hit_vec;
	logic [CAPACITY:0]   shift_chain;
	part_t               cur_re [CAPACITY];
	part_t               cur_im [CAPACITY];

	logic                out_free;
	logic                do_apply;
	logic                accept;
	logic                found;
	logic                full;
	status_t             status_nxt;
	logic [CNT_W-1:0]    count_nxt;

	assign out_free  = !out_valid_q || rsp.ready;
	assign do_apply  = (state_q == S_APPLY) && out_free;
	assign req.ready = (state_q == S_IDLE) || do_apply;
	assign accept    = req.valid && req.ready;

	assign found = |hit_vec;
	assign full  = (count_q == CNT_W'(CAPACITY));

	assign ctl.cmp = (state_q == S_CMP);
	assign ctl.ins = do_apply && (cmd_s1 == CMD_INSERT) && !found && !full;
	assign ctl.del = do_apply && (cmd_s1 == CMD_DELETE);

	assign shift_chain[0] = 1'b0;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		part_t nxt_re;
		part_t nxt_im;

		if (k < CAPACITY - 1) begin : g_mid
			assign nxt_re = cur_re[k+1];
			assign nxt_im = cur_im[k+1];
		end else begin : g_last
			// After a delete that shifts it, the last cell is unoccupied, so its new contents never matter.
			assign nxt_re = re_s1;
			assign nxt_im = im_s1;
		end

		cpst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.occupied  (CNT_W'(k) < count_q),
			.is_tail   (CNT_W'(k) == count_q),
			.op_re     (re_s1),
			.op_im     (im_s1),
			.nxt_re    (nxt_re),
			.nxt_im    (nxt_im),
			.shift_in  (shift_chain[k]),
			.cur_re    (cur_re[k]),
			.cur_im    (cur_im[k]),
			.hit_q     (hit_vec[k]),
			.shift_out (shift_chain[k+1])
		);
	end

	always_comb begin
		count_nxt = count_q;
		unique case (cmd_s1)
			CMD_INSERT: begin
				if (found) begin
					status_nxt = STS_MISS;
				end else if (full) begin
					status_nxt = STS_FULL;
				end else begin
					status_nxt = STS_OK;
					count_nxt  = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (found) begin
					status_nxt = STS_OK;
					count_nxt  = count_q - CNT_W'(1);
				end else begin
					status_nxt = STS_MISS;
				end
			end
			default: begin
				// Lookup, and the unused code treated as one.
				status_nxt = found ? STS_OK : STS_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STS_OK;
			entry_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (do_apply) begin
						state_q <= accept ? S_CMP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (do_apply) begin
				out_valid_q <= 1'b1;
				status_q    <= status_nxt;
				entry_q     <= ENTRY_W'(count_nxt);
				count_q     <= count_nxt;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.command;
			re_s1  <= req.real_part;
			im_s1  <= req.imag_part;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_q;

	`CPST_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count beyond capacity")
	`CPST_ASSERT_NOW(a_single_hit, state_q == S_APPLY, $onehot0(hit_vec), "pair stored twice")
	`CPST_ASSERT_NEXT(a_count_hold, !do_apply, $stable(count_q), "count moved outside apply")

endmodule

`default_nettype wire
